// ===== rtl/ssmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_pkg
// Shared types, codes and glyph tables for the seven-segment scan controller.
// ----------------------------------------------------------------------------
package ssmd_pkg;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_CHAR  = 3'd1,
    REQ_DOT   = 3'd2,
    REQ_VALUE = 3'd3,
    REQ_CLEAR = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_BLINK_DIGIT = 2'd1,
    CFG_BLINK_ON    = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] BLINK_PERIOD     = 8'd100;
  localparam logic [7:0] BLINK_ON_RESET   = 8'd50;
  localparam logic [6:0] GLYPH_MINUS      = 7'h40;
  localparam logic [4:0] GLYPH_IDX_V      = 5'd16;
  localparam logic [4:0] GLYPH_IDX_S      = 5'd17;
  localparam logic [4:0] GLYPH_IDX_MINUS  = 5'd18;

  // segments g..a for hex digits, V, S and minus
  function automatic logic [6:0] glyph(input logic [4:0] idx);
    logic [6:0] g;
    case (idx)
      5'd0:    g = 7'h3F;
      5'd1:    g = 7'h06;
      5'd2:    g = 7'h5B;
      5'd3:    g = 7'h4F;
      5'd4:    g = 7'h66;
      5'd5:    g = 7'h6D;
      5'd6:    g = 7'h7D;
      5'd7:    g = 7'h07;
      5'd8:    g = 7'h7F;
      5'd9:    g = 7'h6F;
      5'd10:   g = 7'h77;
      5'd11:   g = 7'h7C;
      5'd12:   g = 7'h39;
      5'd13:   g = 7'h5E;
      5'd14:   g = 7'h79;
      5'd15:   g = 7'h71;
      5'd16:   g = 7'h3E;
      5'd17:   g = 7'h6D;
      5'd18:   g = GLYPH_MINUS;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  // unknown characters and space give a blank pattern
  function automatic logic [6:0] char_glyph(input logic [7:0] c);
    logic [6:0] g;
    g = 7'h00;
    if (c inside {[8'h30:8'h39]}) begin
      g = glyph(5'(c - 8'h30));
    end else if (c inside {[8'h61:8'h66]}) begin
      g = glyph(5'(c - 8'h61 + 8'd10));
    end else if (c inside {[8'h41:8'h46]}) begin
      g = glyph(5'(c - 8'h41 + 8'd10));
    end else if (c == 8'h56) begin
      g = glyph(GLYPH_IDX_V);
    end else if (c == 8'h53) begin
      g = glyph(GLYPH_IDX_S);
    end else if (c == 8'h2D) begin
      g = glyph(GLYPH_IDX_MINUS);
    end
    return g;
  endfunction

endpackage

// ===== rtl/seven_segment_mux_display.sv =====
`timescale 1ns / 1ps
// Flow: an accepted beat waits in the input register until it is processed; a
//   tick's result is then loaded into the result register and held until taken.
// Throughput: one beat per cycle, set by the single processing stage between
//   the input register and the result register; a tick waits while a result is held.
// Reset: digits cleared, scan at position 1 (digit 3), blink counter 0, display enabled,
//   no blinking, blink threshold 50.
// ----------------------------------------------------------------------------
// seven_segment_mux_display
// Three-digit multiplexed seven-segment controller: digit writes, signed
// decimal formatting and a blinking digit scan.
// ----------------------------------------------------------------------------
module seven_segment_mux_display
  import ssmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [2:0]  target,
  input  logic [7:0]  char_code,
  input  logic        dot_on,
  input  logic [15:0] number,
  input  logic [1:0]  decimals,
  input  logic [1:0]  skip_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  segments,
  output logic [2:0]  digit_select,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration
  logic       display_enable;
  logic [1:0] blink_digit;
  logic [7:0] blink_on_ticks;

  // input register
  logic        item_valid;
  logic [2:0]  item_req;
  logic [2:0]  item_target;
  logic [7:0]  item_char;
  logic        item_dot;
  logic [15:0] item_number;
  logic [1:0]  item_decimals;
  logic [1:0]  item_skip;

  // state
  logic [7:0] digit_store [3];
  logic [7:0] digit_store_next [3];
  logic [1:0] scan_position, scan_position_next;
  logic [7:0] blink_count, blink_count_next;

  logic fire, is_tick;
  logic [7:0] seg_next;
  logic [2:0] sel_next;

  assign cfg_ready = 1'b1;
  assign is_tick   = (item_req == REQ_TICK);
  assign fire      = item_valid && (!is_tick || !out_valid || out_ready);
  assign in_ready  = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable <= 1'b1;
      blink_digit    <= 2'd0;
      blink_on_ticks <= BLINK_ON_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:      display_enable <= cfg_data[0];
        CFG_BLINK_DIGIT: blink_digit    <= cfg_data[1:0];
        CFG_BLINK_ON:    blink_on_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_req      <= req_type;
      item_target   <= target;
      item_char     <= char_code;
      item_dot      <= dot_on;
      item_number   <= number;
      item_decimals <= decimals;
      item_skip     <= skip_high;
    end
  end

  // ---------------- decimal split ----------------
  logic        neg;
  logic [15:0] mag;
  logic [31:0] prod10;
  logic [28:0] prod100;
  logic [32:0] prod1000;
  logic [12:0] q1;
  logic [9:0]  q2;
  logic [6:0]  q3;
  logic [15:0] rem0;
  logic [12:0] rem1;
  logic [9:0]  rem2;
  logic [3:0]  dec_digit [3];
  logic [1:0]  dec_eff;
  logic [1:0]  count;

  assign neg = item_number[15];
  assign mag = neg ? 16'(16'd0 - item_number) : item_number;

  // reciprocal multiplies, exact over the 16-bit range
  assign prod10   = 32'(mag) * 32'd52429;
  assign prod100  = 29'(mag) * 29'd5243;
  assign prod1000 = 33'(mag) * 33'd67109;
  assign q1 = prod10[31:19];
  assign q2 = prod100[28:19];
  assign q3 = prod1000[32:26];

  assign rem0 = mag - (16'({q1, 3'b000}) + 16'({q1, 1'b0}));
  assign rem1 = q1 - (13'({q2, 3'b000}) + 13'({q2, 1'b0}));
  assign rem2 = q2 - (10'({q3, 3'b000}) + 10'({q3, 1'b0}));
  assign dec_digit[0] = rem0[3:0];
  assign dec_digit[1] = rem1[3:0];
  assign dec_digit[2] = rem2[3:0];

  assign dec_eff = (neg && (mag >= 16'd10)) ? 2'd0 : item_decimals;
  assign count   = 2'd3 - item_skip;

  // ---------------- store update ----------------
  always_comb begin
    logic [7:0] v;
    for (int k = 0; k < 3; k++) begin
      v = digit_store[k];
      if (fire) begin
        case (item_req)
          REQ_CHAR: begin
            if (item_target == 3'(k + 1)) v = {v[7], char_glyph(item_char)};
          end
          REQ_DOT: begin
            if (item_target == 3'(k)) v[7] = item_dot;
          end
          REQ_VALUE: begin
            if (k == 1) v[7] = (dec_eff == 2'd1);
            if (k == 2) v[7] = (dec_eff == 2'd2);
            if (2'(k) < count) begin
              if (neg && (2'(k + 1) == count)) v[6:0] = GLYPH_MINUS;
              else v[6:0] = glyph({1'b0, dec_digit[k]});
            end
          end
          REQ_CLEAR: begin
            if (item_target[k]) v = 8'h00;
          end
          default: ;
        endcase
      end
      digit_store_next[k] = v;
    end
  end

  // ---------------- scan and blink ----------------
  logic       is_focus;
  logic [7:0] blink_inc;
  logic       blank_phase;

  assign is_focus  = (blink_digit != 2'd0) && (2'(3'd4 - {1'b0, blink_digit}) == scan_position);
  assign blink_inc = is_focus ? 8'(blink_count + 8'd1) : blink_count;
  assign blank_phase = is_focus && (blink_inc < blink_on_ticks);

  always_comb begin
    blink_count_next   = blink_count;
    scan_position_next = scan_position;
    seg_next = 8'h00;
    sel_next = 3'b000;
    if (fire && is_tick && display_enable) begin
      // advance: 3 wraps to 1, an invalid zero position goes to 1
      scan_position_next = (scan_position == 2'd3) ? 2'd1 : 2'(scan_position + 2'd1);
      if (blank_phase) begin
        blink_count_next = blink_inc;
      end else begin
        blink_count_next = (blink_inc >= BLINK_PERIOD) ? 8'd0 : blink_inc;
        case (scan_position)
          2'd1: begin seg_next = digit_store[2]; sel_next = 3'b001; end
          2'd2: begin seg_next = digit_store[1]; sel_next = 3'b010; end
          2'd3: begin seg_next = digit_store[0]; sel_next = 3'b100; end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) digit_store[k] <= 8'h00;
      scan_position <= 2'd1;
      blink_count   <= 8'd0;
    end else begin
      for (int k = 0; k < 3; k++) digit_store[k] <= digit_store_next[k];
      scan_position <= scan_position_next;
      blink_count   <= blink_count_next;
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && is_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_tick) begin
      segments     <= seg_next;
      digit_select <= sel_next;
    end
  end

endmodule

// ===== rtl/ssmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmd_checker
// Port-level checks for the seven-segment scan controller.
// ----------------------------------------------------------------------------
module ssmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] segments,
  input logic [2:0] digit_select
);

  // at most one digit driven per beat
  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(digit_select))
    else $error("digit_select not one-hot");

  // a blanked beat carries no segments
  a_blank_dark: assert property (@(posedge clk) disable iff (rst)
    (out_valid && digit_select == 3'b000) |-> segments == 8'h00)
    else $error("segments lit on blanked beat");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(segments) && $stable(digit_select)))
    else $error("result dropped or changed while stalled");

endmodule

bind seven_segment_mux_display ssmd_checker u_ssmd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .segments     (segments),
  .digit_select (digit_select)
);
